FILE: rtl/core/htw_pkg.sv
// Package for the hierarchical timer wheel: shared codes, widths and the
// structures passed between the controller and the row of timer cells.
// No dependencies.
package htw_pkg;

	localparam int TIMEOUT_W = 27;
	localparam int TIME_W    = 64;
	localparam int HANDLE_W  = 5;
	localparam int MS_W      = 32;
	localparam int IDX_W     = 6;
	localparam int DAY_MS    = 86400000;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_REG   = 2'd1,
		KIND_UNREG = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_EXPIRED   = 3'd0,
		EV_REGISTERED = 3'd1,
		EV_POOL_FULL = 3'd2,
		EV_UNREG     = 3'd3,
		EV_TICK_DONE = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                 adv;
		logic                 tick_en;
		logic                 claim_en;
		logic                 unreg_en;
		logic [HANDLE_W-1:0]  unreg_id;
		logic [TIME_W-1:0]    now;
		logic [TIMEOUT_W-1:0] tmo;
		logic                 rep;
	} cell_ctl_t;

	// Status returned by one cell while it holds the scan token.
	typedef struct packed {
		logic hit;
		logic claim;
	} cell_sts_t;

endpackage

FILE: rtl/core/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: controller, output register and
// the row of timer cells through which a scan token travels.
// Depends on htw_pkg and htw_cell.

// Millisecond timer manager holding NUM_TIMERS entries, one per cell in a
// chain. An unregister or unknown item goes to the DONE state and from there
// to the output register. A tick or register item sends a token down the
// chain, one cell a cycle while no expiry waits on a stalled output register,
// and then enters the DONE state. A final result waits in the DONE state
// while the output register is stalled. A register item takes the lowest
// free entry; a tick reports expiries in ascending handle order and finishes
// with a tick-done result flagged by tlast. A new item is taken once the
// previous item's last result is in the output register, while that result
// still waits for its transfer.
module hierarchical_timer_wheel #(
	parameter int NUM_TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // timer_id[4:0], ms[36:5], repeat_req[37], zero fill
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // handle[4:0], at_time[68:5], zero fill
	output logic [2:0]  m_tuser,   // event_res[2:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [26:0] cfg_data   // timeout_limit[26:0]
);

	localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int HW = htw_pkg::HANDLE_W;
	localparam int TW = htw_pkg::TIMEOUT_W;
	localparam int YW = htw_pkg::TIME_W;
	localparam int MW = htw_pkg::MS_W;

	htw_pkg::state_t              state_q, state_d;
	htw_pkg::kind_t               op_q, in_kind;
	htw_pkg::ev_t                 ev_q;
	htw_pkg::cell_ctl_t           ctl;
	htw_pkg::cell_sts_t           sts [NUM_TIMERS];

	logic [YW-1:0]                time_q;
	logic [TW-1:0]                cfg_q;
	logic [TW-1:0]                tmo_q;
	logic                         rep_q;
	logic [HW-1:0]                hdl_q;
	logic [CW-1:0]                cnt_q;
	logic [NUM_TIMERS-1:0]        tok;
	logic [NUM_TIMERS-1:0]        hit_vec, claim_vec;
	logic                         hit_any, claim_any;
	logic                         accept, out_free, adv, scan_end, start;
	logic [TW-1:0]                lim, tmo_new;
	logic [HW-1:0]                in_id;
	logic [MW-1:0]                in_ms;
	logic                         in_rep;

	logic                         m_valid_q, m_last_q;
	htw_pkg::ev_t                 m_ev_q;
	logic [HW-1:0]                m_hdl_q;
	logic [YW-1:0]                m_time_q;
	logic                         load_exp, load_done;

	// Field unpacking.
	assign in_kind = htw_pkg::kind_t'(s_tuser);
	assign in_id   = s_tdata[4:0];
	assign in_ms   = s_tdata[36:5];
	assign in_rep  = s_tdata[37];

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign hit_any  = |hit_vec;
	assign claim_any = |claim_vec;
	assign adv      = !hit_any || out_free;
	assign scan_end = adv && (cnt_q == CW'(NUM_TIMERS - 1));
	assign start    = accept && (in_kind == htw_pkg::KIND_TICK || in_kind == htw_pkg::KIND_REG);
	assign cfg_ready = 1'b1;

	// Effective limit and clamped timeout of a register request.
	always_comb begin
		if (cfg_q == '0) begin
			lim = TW'(1);
		end else if (cfg_q > TW'(htw_pkg::DAY_MS)) begin
			lim = TW'(htw_pkg::DAY_MS);
		end else begin
			lim = cfg_q;
		end
		if (in_ms > MW'(lim)) begin
			tmo_new = lim;
		end else if (in_ms == '0) begin
			tmo_new = TW'(1);
		end else begin
			tmo_new = in_ms[TW-1:0];
		end
	end

	// Broadcast to the cells.
	always_comb begin
		ctl.adv      = adv;
		ctl.tick_en  = (state_q == htw_pkg::ST_SCAN) && (op_q == htw_pkg::KIND_TICK);
		ctl.claim_en = (state_q == htw_pkg::ST_SCAN) && (op_q == htw_pkg::KIND_REG)
			&& (ev_q == htw_pkg::EV_POOL_FULL);
		ctl.unreg_en = accept && (in_kind == htw_pkg::KIND_UNREG);
		ctl.unreg_id = in_id;
		ctl.now      = time_q;
		ctl.tmo      = tmo_q;
		ctl.rep      = rep_q;
	end

	// Row of cells; the token enters at cell 0 and moves one cell a cycle while adv is high.
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		logic tin;
		if (i == 0) begin : g_head
			assign tin = start;
		end else begin : g_body
			assign tin = tok[i-1];
		end
		htw_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.token_in (tin),
			.token    (tok[i]),
			.sts      (sts[i])
		);
		assign hit_vec[i]   = sts[i].hit;
		assign claim_vec[i] = sts[i].claim;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htw_pkg::ST_IDLE: begin
				if (start) begin
					state_d = htw_pkg::ST_SCAN;
				end else if (accept) begin
					state_d = htw_pkg::ST_DONE;
				end
			end
			htw_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = htw_pkg::ST_DONE;
				end
			end
			htw_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = htw_pkg::ST_IDLE;
				end
			end
			default: state_d = htw_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready  = 1'b0;
		load_exp  = 1'b0;
		load_done = 1'b0;
		unique case (state_q)
			htw_pkg::ST_IDLE: s_tready  = 1'b1;
			htw_pkg::ST_SCAN: load_exp  = hit_any && out_free;
			htw_pkg::ST_DONE: load_done = out_free;
			default: ;
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htw_pkg::ST_IDLE;
			time_q  <= '0;
			cfg_q   <= TW'(htw_pkg::DAY_MS);
			cnt_q   <= '0;
			op_q    <= htw_pkg::KIND_TICK;
			ev_q    <= htw_pkg::EV_TICK_DONE;
			hdl_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (accept) begin
				op_q  <= in_kind;
				cnt_q <= '0;
				hdl_q <= '0;
				case (in_kind)
					htw_pkg::KIND_TICK: begin
						time_q <= time_q + YW'(1);
						ev_q   <= htw_pkg::EV_TICK_DONE;
					end
					htw_pkg::KIND_REG: ev_q <= htw_pkg::EV_POOL_FULL;
					htw_pkg::KIND_UNREG: begin
						ev_q  <= htw_pkg::EV_UNREG;
						hdl_q <= in_id;
					end
					default: ev_q <= htw_pkg::EV_UNREG;
				endcase
			end else if (state_q == htw_pkg::ST_SCAN) begin
				if (adv) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (claim_any) begin
					ev_q  <= htw_pkg::EV_REGISTERED;
					hdl_q <= HW'(cnt_q);
				end
			end
		end
	end

	// Request payload held for the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			tmo_q <= tmo_new;
			rep_q <= in_rep;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_exp || load_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_exp) begin
			m_ev_q   <= htw_pkg::EV_EXPIRED;
			m_hdl_q  <= HW'(cnt_q);
			m_time_q <= time_q;
			m_last_q <= 1'b0;
		end else if (load_done) begin
			m_ev_q   <= ev_q;
			m_hdl_q  <= hdl_q;
			m_time_q <= time_q;
			m_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_ev_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {3'b000, m_time_q, m_hdl_q};

`ifndef SYNTHESIS
	// At most one cell holds the scan token.
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one cell holds the scan token");

	// Expiries are only seen during a tick scan.
	a_hit_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		hit_any |-> (state_q == htw_pkg::ST_SCAN && op_q == htw_pkg::KIND_TICK))
		else $error("expiry reported outside a tick scan");

	// A register request claims at most one entry.
	a_single_claim: assert property (@(posedge clk) disable iff (!arst_n)
		claim_any |=> !claim_any && ev_q == htw_pkg::EV_REGISTERED)
		else $error("register request claimed more than one entry");

	// The token has left the chain once the final result is pending.
	a_token_gone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htw_pkg::ST_DONE) |-> (tok == '0))
		else $error("scan token still in the chain at the final result");

	// The final result of an item is presented with tlast once it is loaded.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_done |=> m_tvalid && m_tlast)
		else $error("final result not presented with tlast");
`endif

endmodule

FILE: rtl/core/htw_cell.sv
// One timer entry of the wheel: valid flag, expiry, timeout and repeat flag,
// plus the scan token stage that is handed to the next cell.
// Depends on htw_pkg.
module htw_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  htw_pkg::cell_ctl_t  ctl,
	input  logic                token_in,
	output logic                token,
	output htw_pkg::cell_sts_t  sts
);

	logic                             valid_q;
	logic                             token_q;
	logic                             repeat_q;
	logic [htw_pkg::TIMEOUT_W-1:0]    timeout_q;
	logic [htw_pkg::TIME_W-1:0]       expiry_q;
	logic                             id_match;

	// The entry answers only while it holds the token.
	always_comb begin
		sts.hit   = token_q && valid_q && ctl.tick_en && (expiry_q == ctl.now);
		sts.claim = token_q && !valid_q && ctl.claim_en;
	end

	assign token    = token_q;
	assign id_match = ({1'b0, ctl.unreg_id} == htw_pkg::IDX_W'(IDX));

	// Token stage and valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.adv) begin
				token_q <= token_in;
			end
			if (ctl.unreg_en && id_match) begin
				valid_q <= 1'b0;
			end else if (ctl.adv && sts.hit && !repeat_q) begin
				valid_q <= 1'b0;
			end else if (ctl.adv && sts.claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Entry payload: armed on a claim, re-armed on a repeating expiry.
	always_ff @(posedge clk) begin
		if (ctl.adv && sts.claim) begin
			timeout_q <= ctl.tmo;
			repeat_q  <= ctl.rep;
			expiry_q  <= ctl.now + htw_pkg::TIME_W'(ctl.tmo);
		end else if (ctl.adv && sts.hit && repeat_q) begin
			expiry_q  <= ctl.now + htw_pkg::TIME_W'(timeout_q);
		end
	end

endmodule
